// ===== src/tqwps_pkg.sv =====
// Shared types and constants for the two-queue weighted priority server.
// No dependencies; every other file but tqwps_if imports this package.

package tqwps_pkg;

	localparam int ID_W       = 16;
	localparam int AGE_W      = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	// Command codes carried on the request channel.
	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_SERVE = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_AGE_THRESHOLD  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_BURST = 1'd1;

	localparam logic [AGE_W-1:0] AGE_THRESHOLD_RST  = 8'd60;
	localparam logic [7:0]       PRIORITY_BURST_RST = 8'd1;

	typedef enum logic [1:0] {
		ST_ADDED   = 2'd0,
		ST_DROPPED = 2'd1,
		ST_SERVED  = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	// One queue entry: the id in the upper bits, the age in the lower bits.
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [AGE_W-1:0] age;
	} entry_t;

	// Occupancy flags a queue reports to the scheduling logic.
	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

endpackage

// ===== src/tqwps_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on nothing; widths follow the request and response field lists.

interface tqwps_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [15:0] person_id;
	logic [7:0]  age;

	modport source (output valid, output cmd, output person_id, output age, input ready);
	modport sink   (input valid, input cmd, input person_id, input age, output ready);
endinterface

interface tqwps_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] served_id;
	logic [7:0]  served_age;
	logic        from_priority;

	modport source (output valid, output status, output served_id, output served_age,
		output from_priority, input ready);
	modport sink   (input valid, input status, input served_id, input served_age,
		input from_priority, output ready);
endinterface

// ===== src/tqwps_queue.sv =====
// One bounded FIFO of person entries: storage memory, head, tail and count.
// Depends on tqwps_pkg for the entry and status types.

module tqwps_queue import tqwps_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  logic   pop,
	input  entry_t wdata,
	output entry_t rdata,
	output qstat_t stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	entry_t        mem_q [DEPTH];
	entry_t        rdata_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;

	// Storage and read port; the read data holds until the next pop.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[tail_q] <= wdata;
		end
		if (pop) begin
			rdata_q <= mem_q[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q  <= (tail_q == LAST) ? '0 : tail_q + AW'(1);
				count_q <= count_q + CW'(1);
			end else if (pop) begin
				head_q  <= (head_q == LAST) ? '0 : head_q + AW'(1);
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign rdata      = rdata_q;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CW'(DEPTH));

endmodule

// ===== src/two_queue_weighted_priority_server.sv =====
// Top level of the two-queue weighted priority server.
// Depends on tqwps_pkg, the channel interfaces in tqwps_if and tqwps_queue.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+-------------------------------------------
//   req     | in  | valid/ready          | cmd, person_id, age
//   rsp     | out | valid/ready          | status, served_id, served_age, from_priority
//   cfg     | in  | cfg_we, no back-press| cfg_idx, cfg_data
//
// Every request produces exactly one response. It passes through the input
// register, where the scheduling decision and the queue update happen, and
// then the response register, while the queue memory read completes. One
// request is accepted per cycle when the response side keeps up. A stalled
// response holds the pipeline; req.ready drops once both stages are full
// and rsp.ready is low. Reset empties both queues; it needs no clearing pass.

module two_queue_weighted_priority_server import tqwps_pkg::*; #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tqwps_req_if.sink             req,
	tqwps_rsp_if.source           rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers and the burst credit.
	logic [AGE_W-1:0] thr_q;
	logic [7:0]       burst_q;
	logic [7:0]       credit_q;

	// Input stage: the accepted request.
	logic             valid_s1;
	logic             cmd_s1;
	entry_t           entry_s1;

	// Response stage: decision results, waiting for the memory read data.
	logic             valid_s2;
	status_t          status_s2;
	logic             prio_s2;

	logic             adv_s2;
	logic             fire_s1;

	// Scheduling decision for the request in the input stage.
	logic             to_prio;
	logic             serve_prio;
	logic             push_p, push_n, pop_p, pop_n;
	status_t          status_d;
	logic             prio_d;

	qstat_t           stat_p, stat_n;
	entry_t           rdata_p, rdata_n;
	entry_t           served;

	// The response register frees up when it is empty or being taken, and the
	// input register moves forward whenever the response register frees up.
	assign adv_s2    = !valid_s2 || rsp.ready;
	assign fire_s1   = valid_s1 && adv_s2;
	assign req.ready = !valid_s1 || adv_s2;

	always_comb begin
		to_prio    = (entry_s1.age > thr_q);
		serve_prio = !stat_p.empty && (credit_q != '0);
		push_p     = 1'b0;
		push_n     = 1'b0;
		pop_p      = 1'b0;
		pop_n      = 1'b0;
		prio_d     = 1'b0;
		status_d   = ST_EMPTY;
		if (cmd_s1 == CMD_ADD) begin
			// An add lands in the queue picked by age; a full queue drops it.
			prio_d = to_prio;
			if (to_prio) begin
				push_p   = fire_s1 && !stat_p.full;
				status_d = stat_p.full ? ST_DROPPED : ST_ADDED;
			end else begin
				push_n   = fire_s1 && !stat_n.full;
				status_d = stat_n.full ? ST_DROPPED : ST_ADDED;
			end
		end else if (serve_prio) begin
			pop_p    = fire_s1;
			prio_d   = 1'b1;
			status_d = ST_SERVED;
		end else if (!stat_n.empty) begin
			pop_n    = fire_s1;
			status_d = ST_SERVED;
		end
	end

	tqwps_queue #(.DEPTH(QUEUE_DEPTH)) u_prio_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push_p),
		.pop    (pop_p),
		.wdata  (entry_s1),
		.rdata  (rdata_p),
		.stat   (stat_p)
	);

	tqwps_queue #(.DEPTH(QUEUE_DEPTH)) u_norm_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push_n),
		.pop    (pop_n),
		.wdata  (entry_s1),
		.rdata  (rdata_n),
		.stat   (stat_n)
	);

	// Input register; the payload needs no reset.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1       <= req.cmd;
			entry_s1.id  <= req.person_id;
			entry_s1.age <= req.age;
		end
	end

	// Response register payload.
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			status_s2 <= status_d;
			prio_s2   <= prio_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			thr_q    <= AGE_THRESHOLD_RST;
			burst_q  <= PRIORITY_BURST_RST;
			credit_q <= PRIORITY_BURST_RST;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv_s2) begin
				valid_s2 <= fire_s1;
			end
			// A priority serve spends one credit. Any other serve, whether it
			// pops the normal queue or finds nothing, reloads the full burst.
			if (fire_s1 && cmd_s1 == CMD_SERVE) begin
				if (serve_prio) begin
					credit_q <= credit_q - 8'd1;
				end else begin
					credit_q <= burst_q;
				end
			end
			// Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
			if (cfg_we) begin
				case (cfg_idx)
					REG_AGE_THRESHOLD: begin
						thr_q <= cfg_data;
					end
					REG_PRIORITY_BURST: begin
						burst_q  <= cfg_data;
						credit_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// The served entry comes straight from the read register of the queue
	// that was popped; other responses report zeros.
	assign served = prio_s2 ? rdata_p : rdata_n;

	assign rsp.valid         = valid_s2;
	assign rsp.status        = status_s2;
	assign rsp.from_priority = prio_s2;
	assign rsp.served_id     = (status_s2 == ST_SERVED) ? served.id  : '0;
	assign rsp.served_age    = (status_s2 == ST_SERVED) ? served.age : '0;

endmodule

// ===== src/tqwps_chk.sv =====
// Port-level checker for the two-queue weighted priority server, with its bind.
// Depends on tqwps_pkg for the status codes.

module tqwps_chk import tqwps_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic [15:0] rsp_served_id,
	input logic [7:0]  rsp_served_age,
	input logic        rsp_from_priority
);

	// Only a serve that found someone reports an id and an age.
	a_zero_unless_served: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_SERVED |-> rsp_served_id == '0 && rsp_served_age == '0)
		else $error("served fields nonzero on a response that served nobody");

	// A serve that found nobody names no queue.
	a_empty_no_queue: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_EMPTY |-> !rsp_from_priority)
		else $error("empty serve flagged as priority");

	// A stalled response holds its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_served_id) && $stable(rsp_served_age)
			&& $stable(rsp_from_priority))
		else $error("response changed while stalled");

endmodule

bind two_queue_weighted_priority_server tqwps_chk u_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_served_id     (rsp.served_id),
	.rsp_served_age    (rsp.served_age),
	.rsp_from_priority (rsp.from_priority)
);

// ===== bench/tb_two_queue_weighted_priority_server.sv =====
`timescale 1ns / 100ps
// Self-checking bench for two_queue_weighted_priority_server: drives add and serve requests,
// predicts each response in a scoreboard class and compares it field by field.
// Depends on tqwps_pkg, the channel interfaces in tqwps_if and the block's RTL.

module tb_two_queue_weighted_priority_server;
	import tqwps_pkg::*;

	localparam int LINE_DEPTH   = 64;
	localparam int ITEM_TARGET  = 1850;
	localparam int IDLE_PCT     = 36;
	// Two pipeline stages, so a handful of cycles is plenty to see a stray response.
	localparam int DRAIN_CYCLES = 8;
	localparam int TIMEOUT_NS   = 1_000_000;

	// One predicted response.
	typedef struct {
		status_t          status;
		logic [ID_W-1:0]  id;
		logic [AGE_W-1:0] age;
		logic             prio;
	} outcome_t;

	// Tracks both waiting lines and the burst credit, and keeps the responses
	// still owed by the block in request order.
	class queue_server_tracker;
		entry_t           priority_line[$];
		entry_t           normal_line[$];
		logic [AGE_W-1:0] threshold;
		logic [7:0]       burst;
		logic [7:0]       credit;
		outcome_t         owed_responses[$];
		int               mismatches;

		function new();
			threshold  = AGE_THRESHOLD_RST;
			burst      = PRIORITY_BURST_RST;
			credit     = PRIORITY_BURST_RST;
			mismatches = 0;
		endfunction

		function void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_AGE_THRESHOLD: threshold = data;
			REG_PRIORITY_BURST: begin
				burst  = data;
				credit = data;
			end
			default: ;
			endcase
		endfunction

		function void note_request(logic cmd, logic [ID_W-1:0] id, logic [AGE_W-1:0] age);
			outcome_t o;
			entry_t   e;
			o.status = ST_ADDED;
			o.id     = '0;
			o.age    = '0;
			o.prio   = 1'b0;
			if (cmd == CMD_ADD) begin
				e.id   = id;
				e.age  = age;
				o.prio = (age > threshold);
				if (o.prio) begin
					if (priority_line.size() >= LINE_DEPTH)
						o.status = ST_DROPPED;
					else
						priority_line.push_back(e);
				end else begin
					if (normal_line.size() >= LINE_DEPTH)
						o.status = ST_DROPPED;
					else
						normal_line.push_back(e);
				end
			end else if (priority_line.size() != 0 && credit != 0) begin
				e        = priority_line.pop_front();
				credit   = credit - 8'd1;
				o.status = ST_SERVED;
				o.prio   = 1'b1;
				o.id     = e.id;
				o.age    = e.age;
			end else begin
				if (normal_line.size() != 0) begin
					e        = normal_line.pop_front();
					o.status = ST_SERVED;
					o.id     = e.id;
					o.age    = e.age;
				end else begin
					o.status = ST_EMPTY;
				end
				credit = burst;
			end
			owed_responses.push_back(o);
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("[%0t] response mismatch: %s", $time, what);
		endtask

		task check_response(logic [1:0] status, logic [ID_W-1:0] id, logic [AGE_W-1:0] age,
				logic prio);
			outcome_t o;
			if (owed_responses.size() == 0) begin
				report_mismatch($sformatf("unexpected response, status %0d id %h", status, id));
			end else begin
				o = owed_responses.pop_front();
				if (status !== o.status)
					report_mismatch($sformatf("status %0d, expected %0d", status, o.status));
				if (id !== o.id)
					report_mismatch($sformatf("served_id %h, expected %h", id, o.id));
				if (age !== o.age)
					report_mismatch($sformatf("served_age %0d, expected %0d", age, o.age));
				if (prio !== o.prio)
					report_mismatch($sformatf("from_priority %b, expected %b", prio, o.prio));
			end
		endtask

		function int pending();
			return owed_responses.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	tqwps_req_if req_ch();
	tqwps_rsp_if rsp_ch();

	queue_server_tracker tracker;

	// While set, neither the request side nor the response side pauses.
	logic steady_run;
	int   items_sent;

	two_queue_weighted_priority_server #(.QUEUE_DEPTH(LINE_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// The response side pauses at random on each falling edge, unless a steady
	// stretch is running.
	always @(negedge clk) begin
		rsp_ch.ready = steady_run || ($urandom_range(99) >= IDLE_PCT);
	end

	// Every response taken at a rising edge is compared with the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			tracker.check_response(rsp_ch.status, rsp_ch.served_id, rsp_ch.served_age,
				rsp_ch.from_priority);
	end

	// Presents one request, called and returning at a falling edge. Random idle
	// cycles go in front of it; valid stays high when requests follow back to back.
	task automatic send_request(logic cmd, logic [ID_W-1:0] id, logic [AGE_W-1:0] age);
		while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid     = 1'b1;
		req_ch.cmd       = cmd;
		req_ch.person_id = id;
		req_ch.age       = age;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		tracker.note_request(cmd, id, age);
		items_sent++;
		@(negedge clk);
		// The request is taken; a following request raises valid again at once.
		req_ch.valid = 1'b0;
	endtask

	// Register write; only called while no response is owed, so the block is idle.
	task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we   = 1'b1;
		cfg_idx  = idx;
		cfg_data = data;
		@(posedge clk);
		tracker.apply_setting(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic wait_drained();
		while (tracker.pending() != 0)
			@(negedge clk);
	endtask

	initial begin
		int               phase;
		int               len;
		int               add_pct;
		logic [AGE_W-1:0] new_threshold;
		logic [7:0]       new_burst;
		logic [AGE_W-1:0] age_pick;

		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.cmd       = CMD_ADD;
		req_ch.person_id = '0;
		req_ch.age       = '0;
		rsp_ch.ready     = 1'b0;
		cfg_we           = 1'b0;
		cfg_idx          = REG_AGE_THRESHOLD;
		cfg_data         = '0;
		steady_run       = 1'b0;
		items_sent       = 0;
		tracker          = new();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed opening under the reset settings (threshold 60, burst 1).
		// A serve with both lines empty reports nothing to serve.
		send_request(CMD_SERVE, 16'h1234, 8'h55);
		// Extreme ids and ages, and ages on both sides of the threshold.
		send_request(CMD_ADD, 16'h0000, 8'd0);
		send_request(CMD_ADD, 16'hFFFF, 8'd255);
		send_request(CMD_ADD, 16'h0A0A, 8'd60);
		send_request(CMD_ADD, 16'h5A5A, 8'd61);
		send_request(CMD_ADD, 16'hA5A5, 8'd200);
		// With a burst of one, serves alternate between the two lines.
		repeat (5) send_request(CMD_SERVE, 16'hFFFF, 8'hFF);
		// Credit is spent and the normal line is empty: nothing is served even
		// though a priority entry waits, and the credit reloads for the next serve.
		send_request(CMD_ADD, 16'h7E57, 8'd100);
		send_request(CMD_SERVE, 16'h0000, 8'h00);
		send_request(CMD_SERVE, 16'h0000, 8'h00);

		// A zero burst starves the priority line completely.
		wait_drained();
		write_setting(REG_PRIORITY_BURST, 8'd0);
		send_request(CMD_ADD, 16'h0BAD, 8'd90);
		send_request(CMD_SERVE, 16'h1111, 8'h11);
		send_request(CMD_ADD, 16'h600D, 8'd10);
		send_request(CMD_SERVE, 16'h2222, 8'h22);

		// Random phases. Each one starts idle with fresh settings, extremes
		// included, then runs a stream that tends to fill the lines up to the
		// point of dropping, to drain them dry, or to stay balanced.
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			wait_drained();
			steady_run = (phase == 4);

			case ($urandom_range(3))
			0: new_threshold = 8'd0;
			1: new_threshold = 8'd255;
			2: new_threshold = AGE_THRESHOLD_RST;
			default: new_threshold = AGE_W'($urandom_range(255));
			endcase
			if (phase == 0 || $urandom_range(9) < 7)
				write_setting(REG_AGE_THRESHOLD, new_threshold);

			case ($urandom_range(3))
			0: new_burst = 8'd0;
			1: new_burst = 8'd1;
			2: new_burst = 8'd255;
			default: new_burst = 8'($urandom_range(6, 2));
			endcase
			if (phase == 0 || $urandom_range(9) < 7)
				write_setting(REG_PRIORITY_BURST, new_burst);

			case ($urandom_range(2))
			0: add_pct = 80;
			1: add_pct = 25;
			default: add_pct = 50;
			endcase
			len = steady_run ? 300 : $urandom_range(160, 40);

			repeat (len) begin
				// Ages cluster around the current threshold so both lines see traffic.
				case ($urandom_range(5))
				0: age_pick = tracker.threshold;
				1: age_pick = tracker.threshold + 8'd1;
				2: age_pick = 8'd0;
				3: age_pick = 8'd255;
				default: age_pick = AGE_W'($urandom_range(255));
				endcase
				if ($urandom_range(99) < add_pct)
					send_request(CMD_ADD, ID_W'($urandom_range(16'hFFFF)), age_pick);
				else
					send_request(CMD_SERVE, ID_W'($urandom_range(16'hFFFF)),
						AGE_W'($urandom_range(255)));
			end
			phase++;
		end

		req_ch.valid = 1'b0;
		steady_run   = 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (tracker.mismatches == 0) begin
			$display("two_queue_weighted_priority_server regression: pass");
		end else begin
			$display("two_queue_weighted_priority_server regression: fail");
		end
		$finish;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		#(TIMEOUT_NS);
		$display("two_queue_weighted_priority_server regression: fail");
		$finish;
	end

endmodule
